/* sv/rrt_pkg.sv */
// ---------------------------------------------------------------------------
// rrt_pkg
// Shared types and constants for the reset request tracker.
// ---------------------------------------------------------------------------
package rrt_pkg;

	localparam int          PADDR_W       = 3;
	localparam int          PDATA_W       = 32;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

	// register index, taken from paddr[2]
	localparam logic REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		REQ_STATUS = 2'd0,
		REQ_BEGIN  = 2'd1,
		REQ_CANCEL = 2'd2,
		REQ_TICK   = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		BS_NONE        = 3'd0,
		BS_STARTED     = 3'd1,
		BS_BAD_SESSION = 3'd2,
		BS_PENDING     = 3'd3,
		BS_NO_CONTEXT  = 3'd4
	} begin_status_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [31:0] seq;
		logic [31:0] session_id;
		logic [31:0] now_ms;
		logic [31:0] boot_id;
		logic [31:0] challenge;
		logic        has_result;
		logic        result_ok;
		logic [7:0]  result_error;
	} req_item_t;

	typedef struct packed {
		begin_status_t begin_status;
		logic [31:0]   tgt_boot_id;
		logic [31:0]   target_challenge;
		logic          outcome_valid;
		logic [31:0]   outcome_seq;
		logic          outcome_ok;
		logic          outcome_timed_out;
		logic [7:0]    outcome_error;
	} res_item_t;

endpackage

/* sv/rrt_regs.sv */
// ---------------------------------------------------------------------------
// rrt_regs
// APB register file: holds the request timeout in milliseconds.
// ---------------------------------------------------------------------------
module rrt_regs
	import rrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [31:0]        timeout_lim
);

	logic        wr_en;
	logic [31:0] timeout_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			timeout_q <= pwdata;
		end
	end

	assign prdata      = (paddr[2] == REG_TIMEOUT) ? timeout_q : '0;
	assign timeout_lim = timeout_q;

endmodule

/* sv/rrt_track.sv */
// ---------------------------------------------------------------------------
// rrt_track
// Request state and per-request decision logic. State commits when the
// request in the input register moves into the result register.
// ---------------------------------------------------------------------------
module rrt_track
	import rrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  req_item_t   item,
	input  logic [31:0] timeout_lim,
	output res_item_t   res
);

	logic        pending_q;
	logic        context_ok_q;
	logic [31:0] pend_seq_q;
	logic [31:0] pend_session_q;
	logic [31:0] pend_boot_q;
	logic [31:0] pend_since_q;
	logic [31:0] latest_boot_q;
	logic [31:0] latest_chal_q;

	logic        result_match;
	logic        start;
	logic        close;
	logic [31:0] elapsed;

	assign result_match = pending_q && item.has_result && (item.boot_id == pend_boot_q)
		&& (item.seq == pend_seq_q) && (item.session_id == pend_session_q);
	assign elapsed = item.now_ms - pend_since_q;

	always_comb begin
		res   = '0;
		start = 1'b0;
		close = 1'b0;
		unique case (item.req_type)
			REQ_STATUS: begin
				if (result_match) begin
					close             = 1'b1;
					res.outcome_valid = 1'b1;
					res.outcome_seq   = pend_seq_q;
					res.outcome_ok    = item.result_ok;
					res.outcome_error = item.result_error;
				end
			end
			REQ_BEGIN: begin
				priority if (item.session_id == '0) begin
					res.begin_status = BS_BAD_SESSION;
				end else if (pending_q) begin
					res.begin_status = BS_PENDING;
				end else if (!context_ok_q) begin
					res.begin_status = BS_NO_CONTEXT;
				end else begin
					start                = 1'b1;
					res.begin_status     = BS_STARTED;
					res.tgt_boot_id      = latest_boot_q;
					res.target_challenge = latest_chal_q;
				end
			end
			REQ_CANCEL: begin
				close = pending_q && (pend_seq_q == item.seq);
			end
			REQ_TICK: begin
				if (pending_q && (elapsed >= timeout_lim)) begin
					close                 = 1'b1;
					res.outcome_valid     = 1'b1;
					res.outcome_seq       = pend_seq_q;
					res.outcome_timed_out = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= 1'b0;
			context_ok_q <= 1'b0;
		end else if (step) begin
			if (start) begin
				pending_q <= 1'b1;
			end else if (close) begin
				pending_q <= 1'b0;
			end
			if (item.req_type == REQ_STATUS) begin
				context_ok_q <= (item.boot_id != '0) && (item.challenge != '0);
			end
		end
	end

	// payload state, only read once written
	always_ff @(posedge clk) begin
		if (step && item.req_type == REQ_STATUS) begin
			latest_boot_q <= item.boot_id;
			latest_chal_q <= item.challenge;
		end
		if (step && start) begin
			pend_seq_q     <= item.seq;
			pend_session_q <= item.session_id;
			pend_boot_q    <= latest_boot_q;
			pend_since_q   <= item.now_ms;
		end
	end

endmodule

/* sv/reset_request_tracker_top.sv */
// ---------------------------------------------------------------------------
// reset_request_tracker_top
// Tracks one outstanding reset request to a partner device.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------
//   in       | in_valid / in_stall   | req_type, seq, ... result_error
//   out      | out_valid / out_stall | begin_status, ... outcome_error
//   config   | APB psel / penable    | paddr, pwdata, prdata
//
// One request per cycle while out_stall is low; a request passes through the
// input register, then the result register. Request state updates as a request
// moves into the result register, so the next request sees it at once.
// out_stall holds the result register; in_stall rises only when both
// registers are full. Reset clears the pending flag and context and sets the timeout to TIMEOUT_RESET.
// ---------------------------------------------------------------------------
module reset_request_tracker_top
	import rrt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [31:0]        seq,
	input  logic [31:0]        session_id,
	input  logic [31:0]        now_ms,
	input  logic [31:0]        boot_id,
	input  logic [31:0]        challenge,
	input  logic               has_result,
	input  logic               result_ok,
	input  logic [7:0]         result_error,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         begin_status,
	output logic [31:0]        tgt_boot_id,
	output logic [31:0]        target_challenge,
	output logic               outcome_valid,
	output logic [31:0]        outcome_seq,
	output logic               outcome_ok,
	output logic               outcome_timed_out,
	output logic [7:0]         outcome_error,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic        valid_s1;
	logic        valid_s2;
	req_item_t   item_s1;
	res_item_t   res_s2;
	res_item_t   res_next;
	logic [31:0] timeout_lim;
	logic        advance;
	logic        in_take;
	logic        step;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;
	assign step     = valid_s1 && advance;

	rrt_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.timeout_lim (timeout_lim)
	);

	rrt_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.timeout_lim (timeout_lim),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.req_type     <= req_type_t'(req_type);
			item_s1.seq          <= seq;
			item_s1.session_id   <= session_id;
			item_s1.now_ms       <= now_ms;
			item_s1.boot_id      <= boot_id;
			item_s1.challenge    <= challenge;
			item_s1.has_result   <= has_result;
			item_s1.result_ok    <= result_ok;
			item_s1.result_error <= result_error;
		end
		if (step) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid         = valid_s2;
	assign begin_status      = res_s2.begin_status;
	assign tgt_boot_id       = res_s2.tgt_boot_id;
	assign target_challenge  = res_s2.target_challenge;
	assign outcome_valid     = res_s2.outcome_valid;
	assign outcome_seq       = res_s2.outcome_seq;
	assign outcome_ok        = res_s2.outcome_ok;
	assign outcome_timed_out = res_s2.outcome_timed_out;
	assign outcome_error     = res_s2.outcome_error;

endmodule

/* sv/rrt_check.sv */
// ---------------------------------------------------------------------------
// rrt_check
// Port-level checks for the reset request tracker, bound to the top level.
// ---------------------------------------------------------------------------
module rrt_check
	import rrt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  begin_status,
	input logic [31:0] tgt_boot_id,
	input logic [31:0] target_challenge,
	input logic        outcome_valid,
	input logic [31:0] outcome_seq,
	input logic        outcome_ok,
	input logic        outcome_timed_out,
	input logic [7:0]  outcome_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(outcome_seq)
			&& $stable(begin_status) && $stable(outcome_valid))
		else $error("stalled request changed");

	a_no_outcome_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !outcome_valid |-> outcome_seq == '0 && !outcome_ok
			&& !outcome_timed_out && outcome_error == '0)
		else $error("outcome fields set without outcome");

	a_target_only_started: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && begin_status != BS_STARTED |->
			tgt_boot_id == '0 && target_challenge == '0)
		else $error("target set without a started request");

	a_timeout_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome_timed_out |-> outcome_valid && !outcome_ok
			&& outcome_error == '0)
		else $error("bad timeout outcome");

	a_begin_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && begin_status != BS_NONE |-> !outcome_valid)
		else $error("begin request closed a request");

endmodule

bind reset_request_tracker_top rrt_check u_rrt_check (.*);
